>>> rtl/lfrw_pkg.sv
package lfrw_pkg;

  localparam int PIXEL_COUNT   = 128;
  localparam int CHANNEL_COUNT = 4;

  localparam int CHAN_BYTES = PIXEL_COUNT * 3;
  localparam int STORE_PIX  = CHANNEL_COUNT * PIXEL_COUNT;
  localparam int ADDR_W     = (STORE_PIX > 1) ? $clog2(STORE_PIX) : 1;
  localparam int CH_W       = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int USED_W     = 10;
  localparam int WORD_W     = 24;

  // Multiplying by 683 and dropping 11 bits divides any 9-bit value by three.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [2:0] CMD_SELECT = 3'd0;
  localparam logic [2:0] CMD_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_ACK    = 3'd3;
  localparam logic [2:0] CMD_LOOP   = 3'd4;

  localparam logic [1:0] LANE_GREEN = 2'd0;
  localparam logic [1:0] LANE_RED   = 2'd1;
  localparam logic [1:0] LANE_BLUE  = 2'd2;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } mem_req_t;

endpackage

>>> rtl/lfrw_scale.sv
module lfrw_scale
  import lfrw_pkg::*;
(
  input  logic [31:0]       argb,
  output logic [WORD_W-1:0] grb
);

  function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = 16'(c) * 16'(a);
    s = 17'(p) + 17'(p[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  assign grb = {scale8(argb[7:0], argb[31:24]),
                scale8(argb[23:16], argb[31:24]),
                scale8(argb[15:8], argb[31:24])};

endmodule

>>> rtl/lfrw_store.sv
module lfrw_store
  import lfrw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rd_data,
  output logic              busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_PIX - 1);

  logic [WORD_W-1:0] mem [STORE_PIX];
  logic [WORD_W-1:0] rd_q_r;
  logic              clr_r;
  logic [ADDR_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_q_r;
  assign busy    = clr_r;

endmodule

>>> rtl/led_frame_record_writer.sv
// LED frame record writer for four strip channels of 128 pixels each.
// Records arrive on the in_ channel as a valid/stall transfer; every record
// gives exactly one result on the out_ channel, in order.
// A record enters a single execute stage, where it updates the channel
// selection, the changed flags and the used lengths, and issues at most
// one access to the pixel memory, which holds one GRB word per pixel. A
// pixel write stores all three scaled bytes in one access; a byte read
// fetches the word and picks the byte as the result leaves.
// The execute stage and the output register lie between in_ and out_.
// One record per cycle is sustained while the receiver takes results; the
// single memory port and the one result register set that figure.
// When out_stall holds a result, the execute stage keeps its record and
// in_stall rises, so nothing is lost.
// After reset the pixel memory is cleared one pixel per cycle, with
// in_stall high meanwhile. Selection, flags and lengths clear at once.
module led_frame_record_writer
  import lfrw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_channel_number,
  input  logic [7:0]  in_pixel_number,
  input  logic [31:0] in_argb,
  input  logic [8:0]  in_byte_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [7:0]  out_read_byte,
  output logic [3:0]  out_changed_flags,
  output logic [8:0]  out_used_bytes
);

  logic                     s1_valid_r;
  logic [2:0]               s1_cmd_r;
  logic [7:0]               s1_chn_r;
  logic [7:0]               s1_pix_r;
  logic [31:0]              s1_argb_r;
  logic [8:0]               s1_bidx_r;

  logic                     sel_valid_r, sel_valid_nxt;
  logic [CH_W-1:0]          sel_idx_r, sel_idx_nxt;
  logic [CHANNEL_COUNT-1:0] changed_r, changed_nxt;
  logic [USED_W-1:0]        used_r [CHANNEL_COUNT];

  logic                     out_valid_r;
  logic                     out_accepted_r;
  logic                     out_rd_ok_r;
  logic [1:0]               out_lane_r;
  logic [3:0]               out_changed_r;
  logic [8:0]               out_used_r;

  logic                     adv;
  logic                     commit;
  logic                     in_xfer;
  logic                     store_busy;
  logic                     chn_ok;
  logic [CH_W-1:0]          chn_idx;
  logic                     pix_ok;
  logic                     bidx_ok;
  logic [18:0]              div_prod;
  logic [7:0]               bidx_pix;
  logic [1:0]               lane;
  logic                     acc;
  logic                     wr;
  logic                     rd;
  logic                     look_ok;
  logic [CH_W-1:0]          look_idx;
  logic [USED_W-1:0]        used_cur;
  logic [USED_W-1:0]        used_out;
  logic [USED_W-1:0]        sz;
  logic                     grow;
  logic [WORD_W-1:0]        grb;
  logic [WORD_W-1:0]        rd_word;
  logic [7:0]               rd_byte;
  mem_req_t                 req;

  assign adv      = !out_valid_r || !out_stall;
  assign commit   = s1_valid_r && adv;
  assign in_stall = store_busy || (s1_valid_r && !adv);
  assign in_xfer  = in_valid && !in_stall;

  assign chn_ok   = (s1_chn_r != 8'd0) && (s1_chn_r <= 8'(CHANNEL_COUNT));
  assign chn_idx  = CH_W'(s1_chn_r - 8'd1);
  assign pix_ok   = (s1_pix_r != 8'd0) && (s1_pix_r <= 8'(PIXEL_COUNT));
  assign bidx_ok  = 10'(s1_bidx_r) < 10'(CHAN_BYTES);
  assign div_prod = 19'(s1_bidx_r) * 19'(DIV3_MUL);
  assign bidx_pix = div_prod[DIV3_SHIFT +: 8];
  assign lane     = 2'(10'(s1_bidx_r) - 10'(bidx_pix) * 10'd3);
  assign sz       = USED_W'(s1_pix_r) * USED_W'(3);

  always_comb begin
    sel_valid_nxt = sel_valid_r;
    sel_idx_nxt   = sel_idx_r;
    changed_nxt   = changed_r;
    acc           = 1'b0;
    wr            = 1'b0;
    rd            = 1'b0;
    look_ok       = sel_valid_r;
    look_idx      = sel_idx_r;
    unique case (s1_cmd_r)
      CMD_SELECT: begin
        sel_valid_nxt = chn_ok;
        sel_idx_nxt   = chn_ok ? chn_idx : sel_idx_r;
        acc           = chn_ok;
        look_ok       = chn_ok;
        look_idx      = chn_idx;
      end
      CMD_WRITE: begin
        if (sel_valid_r && pix_ok) begin
          wr          = 1'b1;
          acc         = 1'b1;
          changed_nxt = changed_r | (CHANNEL_COUNT'(1) << sel_idx_r);
        end
      end
      CMD_READ: begin
        look_ok  = chn_ok;
        look_idx = chn_idx;
        if (chn_ok && bidx_ok) begin
          rd  = 1'b1;
          acc = 1'b1;
        end
      end
      CMD_ACK: begin
        look_ok  = chn_ok;
        look_idx = chn_idx;
        if (chn_ok) begin
          changed_nxt = changed_r & ~(CHANNEL_COUNT'(1) << chn_idx);
          acc         = 1'b1;
        end
      end
      CMD_LOOP: begin
        sel_valid_nxt = 1'b0;
        look_ok       = 1'b0;
        acc           = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign used_cur = look_ok ? used_r[look_idx] : '0;
  assign grow     = wr && (used_cur < sz);
  assign used_out = grow ? sz : used_cur;

  lfrw_scale u_scale (
    .argb (s1_argb_r),
    .grb  (grb)
  );

  always_comb begin
    req.we    = commit && wr;
    req.re    = commit && rd;
    req.wdata = grb;
    if (wr) begin
      req.addr = ADDR_W'(sel_idx_r) * ADDR_W'(PIXEL_COUNT) + ADDR_W'(s1_pix_r - 8'd1);
    end else begin
      req.addr = ADDR_W'(chn_idx) * ADDR_W'(PIXEL_COUNT) + ADDR_W'(bidx_pix);
    end
  end

  lfrw_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_word),
    .busy    (store_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sel_valid_r <= 1'b0;
      sel_idx_r   <= '0;
      changed_r   <= '0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        used_r[i] <= '0;
      end
    end else begin
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        sel_valid_r <= sel_valid_nxt;
        sel_idx_r   <= sel_idx_nxt;
        changed_r   <= changed_nxt;
        if (grow) begin
          used_r[sel_idx_r] <= sz;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r  <= in_cmd;
      s1_chn_r  <= in_channel_number;
      s1_pix_r  <= in_pixel_number;
      s1_argb_r <= in_argb;
      s1_bidx_r <= in_byte_index;
    end
    if (commit) begin
      out_accepted_r <= acc;
      out_rd_ok_r    <= rd;
      out_lane_r     <= lane;
      out_changed_r  <= 4'(changed_nxt);
      out_used_r     <= used_out[8:0];
    end
  end

  always_comb begin
    unique case (out_lane_r)
      LANE_GREEN: rd_byte = rd_word[7:0];
      LANE_RED:   rd_byte = rd_word[15:8];
      LANE_BLUE:  rd_byte = rd_word[23:16];
      default:    rd_byte = '0;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_accepted_r;
  assign out_read_byte     = out_rd_ok_r ? rd_byte : 8'd0;
  assign out_changed_flags = out_changed_r;
  assign out_used_bytes    = out_used_r;

`ifndef NO_ASSERTIONS
  a_no_xfer_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    store_busy |-> !in_xfer)
    else $error("input transfer taken while the pixel memory is being cleared");

  a_loop_deselects: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (s1_cmd_r == CMD_LOOP) |=> !sel_valid_r)
    else $error("loop record left a channel selected");

  a_ack_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (s1_cmd_r == CMD_ACK) && chn_ok |=> !changed_r[$past(chn_idx)])
    else $error("acknowledge did not clear the changed flag");

  a_rejected_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_accepted_r |-> out_read_byte == 8'd0)
    else $error("ignored record returned a nonzero byte");

  a_single_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("pixel memory written and read in the same cycle");
`endif

endmodule

>>> sim/led_frame_record_writer_tb.sv
`timescale 1ns / 100ps

module led_frame_record_writer_tb;
  import lfrw_pkg::*;

  localparam int STORE_BYTES      = CHANNEL_COUNT * CHAN_BYTES;
  localparam int BYTES_PER_PIXEL  = 3;
  localparam int FULL_ALPHA       = 255;
  localparam int LONG_HOLD        = 64;
  localparam int RECORD_TOTAL     = 1550;
  localparam logic [2:0] CMD_SPARE_FIRST = CMD_LOOP + 3'd1;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  channel;
    logic [7:0]  pixel;
    logic [31:0] argb;
    logic [8:0]  byte_index;
  } strip_record_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] read_byte;
    logic [3:0] changed;
    logic [8:0] used;
  } strip_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = '0;
  logic [7:0]  in_channel_number = '0;
  logic [7:0]  in_pixel_number = '0;
  logic [31:0] in_argb = '0;
  logic [8:0]  in_byte_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [7:0]  out_read_byte;
  logic [3:0]  out_changed_flags;
  logic [8:0]  out_used_bytes;

  led_frame_record_writer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_channel_number (in_channel_number),
    .in_pixel_number   (in_pixel_number),
    .in_argb           (in_argb),
    .in_byte_index     (in_byte_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_accepted      (out_accepted),
    .out_read_byte     (out_read_byte),
    .out_changed_flags (out_changed_flags),
    .out_used_bytes    (out_used_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  strip_record_t record_queue[$];
  strip_status_t status_queue[$];

  logic [7:0]               strip_bytes [STORE_BYTES];
  logic [8:0]               strip_len [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] dirty_mask;
  int                       sel_strip;

  int   queued_count = 0;
  int   accepted_count = 0;
  int   mismatch_count = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  logic hold_armed = 1'b0;
  logic sender_no_gaps = 1'b0;
  logic sender_burst = 1'b0;
  logic receiver_burst = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_count = 0;

  function automatic bit chan_valid(int n);
    return n >= 1 && n <= CHANNEL_COUNT;
  endfunction

  function automatic logic [8:0] len_of(int n);
    return chan_valid(n) ? strip_len[n-1] : 9'd0;
  endfunction

  function automatic strip_status_t play_record(strip_record_t r);
    strip_status_t res;
    int            base;
    int            alpha;
    int            span;
    res = '0;
    res.used = len_of(sel_strip);
    case (r.cmd)
      CMD_SELECT: begin
        if (chan_valid(int'(r.channel))) begin
          sel_strip = int'(r.channel);
          res.accepted = 1'b1;
        end else begin
          sel_strip = 0;
        end
        res.used = len_of(sel_strip);
      end
      CMD_WRITE: begin
        if (chan_valid(sel_strip) && r.pixel >= 1 && r.pixel <= PIXEL_COUNT) begin
          alpha = int'(r.argb[31:24]);
          base = (sel_strip - 1) * CHAN_BYTES + (r.pixel - 1) * BYTES_PER_PIXEL;
          span = r.pixel * BYTES_PER_PIXEL;
          strip_bytes[base]     = 8'((int'(r.argb[15:8]) * alpha) / FULL_ALPHA);
          strip_bytes[base + 1] = 8'((int'(r.argb[23:16]) * alpha) / FULL_ALPHA);
          strip_bytes[base + 2] = 8'((int'(r.argb[7:0]) * alpha) / FULL_ALPHA);
          dirty_mask[sel_strip - 1] = 1'b1;
          if (strip_len[sel_strip - 1] < span) strip_len[sel_strip - 1] = 9'(span);
          res.accepted = 1'b1;
        end
        res.used = len_of(sel_strip);
      end
      CMD_READ: begin
        res.used = len_of(int'(r.channel));
        if (chan_valid(int'(r.channel)) && r.byte_index < CHAN_BYTES) begin
          res.read_byte = strip_bytes[(r.channel - 1) * CHAN_BYTES + r.byte_index];
          res.accepted = 1'b1;
        end
      end
      CMD_ACK: begin
        res.used = len_of(int'(r.channel));
        if (chan_valid(int'(r.channel))) begin
          dirty_mask[r.channel - 1] = 1'b0;
          res.accepted = 1'b1;
        end
      end
      CMD_LOOP: begin
        sel_strip = 0;
        res.used = '0;
        res.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    res.changed = dirty_mask;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s is %0h, expected %0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin : monitor
    strip_record_t rec;
    strip_status_t exp;
    in_taken <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (status_queue.size() == 0) begin
        report_mismatch("result with none pending, used_bytes", 32'(out_used_bytes), '0);
      end else begin
        exp = status_queue.pop_front();
        if (out_accepted !== exp.accepted)
          report_mismatch("accepted", 32'(out_accepted), 32'(exp.accepted));
        if (out_read_byte !== exp.read_byte)
          report_mismatch("read_byte", 32'(out_read_byte), 32'(exp.read_byte));
        if (out_changed_flags !== exp.changed)
          report_mismatch("changed_flags", 32'(out_changed_flags), 32'(exp.changed));
        if (out_used_bytes !== exp.used)
          report_mismatch("used_bytes", 32'(out_used_bytes), 32'(exp.used));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      rec.cmd = in_cmd;
      rec.channel = in_channel_number;
      rec.pixel = in_pixel_number;
      rec.argb = in_argb;
      rec.byte_index = in_byte_index;
      status_queue.push_back(play_record(rec));
      accepted_count++;
    end
  end

  always @(negedge clk) begin : sender
    strip_record_t rec;
    if (rst_n && (!in_valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (record_queue.size() != 0) begin
        rec = record_queue.pop_front();
        in_cmd <= rec.cmd;
        in_channel_number <= rec.channel;
        in_pixel_number <= rec.pixel;
        in_argb <= rec.argb;
        in_byte_index <= rec.byte_index;
        in_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
        gap_left = (sender_burst || sender_no_gaps) ? 0 : $urandom_range(0, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (hold_armed && hold_count < LONG_HOLD) begin
      hold_count++;
      out_stall <= 1'b1;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
        stall_left = receiver_burst ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic queue_record(logic [2:0] cmd, int chan, int pix, logic [31:0] argb, int bidx);
    strip_record_t rec;
    rec.cmd = cmd;
    rec.channel = 8'(chan);
    rec.pixel = 8'(pix);
    rec.argb = argb;
    rec.byte_index = 9'(bidx);
    record_queue.push_back(rec);
    queued_count++;
  endtask

  function automatic int pick_pixel();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom_range(1, 16);
    if (roll < 9) return $urandom_range(1, PIXEL_COUNT);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [31:0] pick_argb();
    logic [31:0] v;
    int          roll;
    v = $urandom;
    roll = $urandom_range(0, 9);
    if (roll < 3) v[31:24] = 8'(FULL_ALPHA);
    else if (roll == 3) v[31:24] = '0;
    return v;
  endfunction

  function automatic int pick_byte();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom_range(0, 47);
    if (roll < 9) return $urandom_range(0, CHAN_BYTES - 1);
    return $urandom_range(0, 511);
  endfunction

  task automatic add_random(int target);
    int strip;
    int steps;
    int kind;
    while (queued_count < target) begin
      if ($urandom_range(0, 99) < 75) begin
        strip = $urandom_range(1, CHANNEL_COUNT);
        queue_record(CMD_SELECT, strip, $urandom_range(0, 255), $urandom,
                     $urandom_range(0, 511));
        steps = $urandom_range(1, 10);
        repeat (steps) begin
          kind = $urandom_range(0, 9);
          if (kind < 5)
            queue_record(CMD_WRITE, $urandom_range(0, 255), pick_pixel(), pick_argb(),
                         $urandom_range(0, 511));
          else if (kind < 8)
            queue_record(CMD_READ,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, CHANNEL_COUNT) : strip,
                         $urandom_range(0, 255), $urandom, pick_byte());
          else
            queue_record(CMD_ACK, $urandom_range(1, CHANNEL_COUNT), $urandom_range(0, 255),
                         $urandom, $urandom_range(0, 511));
        end
        if ($urandom_range(0, 3) == 0)
          queue_record(CMD_LOOP, $urandom_range(0, 255), $urandom_range(0, 255), $urandom,
                       $urandom_range(0, 511));
      end else begin
        queue_record(3'($urandom_range(0, 7)), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom, $urandom_range(0, 511));
      end
    end
  endtask

  task automatic wait_for_drain();
    do @(negedge clk);
    while (accepted_count != queued_count || status_queue.size() != 0);
  endtask

  initial begin : stimulus
    for (int i = 0; i < STORE_BYTES; i++) strip_bytes[i] = '0;
    for (int i = 0; i < CHANNEL_COUNT; i++) strip_len[i] = '0;
    dirty_mask = '0;
    sel_strip = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads of the cleared store and past the buffer, writes with nothing selected, selects, acks, a loop and spares.
    queue_record(CMD_READ, 1, 0, '0, 0);
    queue_record(CMD_READ, CHANNEL_COUNT, 0, '0, CHAN_BYTES - 1);
    queue_record(CMD_READ, 2, 0, '0, CHAN_BYTES);
    queue_record(CMD_READ, 3, 0, '0, 511);
    queue_record(CMD_WRITE, 0, 1, 32'hffff_ffff, 0);
    queue_record(CMD_SELECT, 0, 0, '0, 0);
    queue_record(CMD_SELECT, CHANNEL_COUNT + 1, 0, '0, 0);
    queue_record(CMD_SELECT, 255, 255, 32'hffff_ffff, 511);
    queue_record(CMD_SELECT, 1, 0, '0, 0);
    queue_record(CMD_WRITE, 1, 0, 32'hffff_ffff, 0);
    queue_record(CMD_WRITE, 1, 1, 32'hffff_ffff, 0);
    queue_record(CMD_WRITE, 1, PIXEL_COUNT, 32'h00ff_ffff, 0);
    queue_record(CMD_WRITE, 1, PIXEL_COUNT + 1, 32'hffff_ffff, 0);
    queue_record(CMD_WRITE, 1, 255, 32'hffff_ffff, 0);
    queue_record(CMD_WRITE, 1, 2, 32'h80c0_40ff, 0);
    queue_record(CMD_READ, 1, 0, '0, 3);
    queue_record(CMD_READ, 1, 0, '0, 5);
    queue_record(CMD_READ, 1, 0, '0, CHAN_BYTES - 1);
    queue_record(CMD_SELECT, CHANNEL_COUNT, 0, '0, 0);
    queue_record(CMD_WRITE, 0, 7, 32'h7f12_3456, 0);
    queue_record(CMD_READ, 1, 0, '0, 200);
    queue_record(CMD_ACK, 1, 0, '0, 0);
    queue_record(CMD_ACK, 0, 0, '0, 0);
    queue_record(CMD_ACK, CHANNEL_COUNT + 1, 0, '0, 0);
    queue_record(CMD_READ, 0, 0, '0, 0);
    queue_record(CMD_LOOP, 0, 0, '0, 0);
    queue_record(CMD_WRITE, 0, 3, 32'hffff_ffff, 0);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      queue_record(3'(c), 1, 1, 32'hffff_ffff, 1);
    wait_for_drain();

    @(posedge clk);
    add_random(RECORD_TOTAL / 2);
    wait_for_drain();

    // The receiver holds off while records arrive back to back.
    @(posedge clk);
    hold_armed = 1'b1;
    sender_no_gaps = 1'b1;
    add_random(queued_count + 300);
    wait_for_drain();

    @(posedge clk);
    sender_no_gaps = 1'b0;
    add_random(RECORD_TOTAL);
    wait_for_drain();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
